### src/pfc_pkg.sv
package pfc_pkg;

    // Input opcodes
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_DONE = 2'd1;
    localparam logic [1:0] OP_TEXT = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    // Letter codes, 0=A..25=Z, 26=space
    localparam logic [4:0] LET_I      = 5'd8;
    localparam logic [4:0] LET_J      = 5'd9;
    localparam logic [4:0] LET_X      = 5'd23;
    localparam logic [4:0] LET_Z      = 5'd25;
    localparam logic [4:0] LAST_LET   = 5'd25;
    localparam logic [4:0] SPACE_CODE = 5'd26;

    localparam int unsigned NUM_LETTERS = 26;
    localparam int unsigned NUM_CELLS   = 25;
    localparam logic [2:0]  LAST_COL    = 3'd4;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [4:0] cipher_letter;
        logic       last_of_run;
        logic       padded_pair;
    } t_out_item;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [4:0] sym;
        logic       space;
    } t_cmd;

endpackage

### src/pfc_front.sv
module pfc_front (
    input  pfc_pkg::t_in_item i_in_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_queue_full,
    output logic              o_push,
    output pfc_pkg::t_cmd     o_cmd
);
    import pfc_pkg::*;

    logic keep;

    // Drop beats that never touch state: bad key letters and bad plaintext codes.
    always_comb begin
        case (i_in_data.opcode)
            OP_KEY:  keep = (i_in_data.symbol <= LAST_LET);
            OP_TEXT: keep = (i_in_data.symbol <= SPACE_CODE);
            default: keep = 1'b1;
        endcase
    end

    assign o_in_ready  = !i_queue_full;
    assign o_push      = i_in_valid && !i_queue_full && keep;
    assign o_cmd.op    = i_in_data.opcode;
    assign o_cmd.sym   = i_in_data.symbol;
    assign o_cmd.space = (i_in_data.symbol == SPACE_CODE);

endmodule

### src/pfc_queue.sv
module pfc_queue #(
    parameter int unsigned DEPTH = pfc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfc_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output pfc_pkg::t_cmd o_cmd
);
    import pfc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### src/pfc_back.sv
module pfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  pfc_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfc_pkg::t_out_item o_out_data
);
    import pfc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_OUT1 = 3'd3;
    localparam logic [2:0] S_OUT2 = 3'd4;

    // Key square by cell, and {row, col} of each letter (J shares the I entry)
    logic [4:0]  r_key_sq [NUM_CELLS];
    logic [5:0]  r_pos    [NUM_LETTERS];

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_fill, n_fill;
    logic [2:0]  r_row, n_row;
    logic [2:0]  r_col, n_col;
    logic [25:0] r_used, n_used;
    logic [4:0]  r_cand, n_cand;
    logic        r_key_ready, n_key_ready;
    logic [4:0]  r_pend, n_pend;
    logic        r_pend_v, n_pend_v;
    logic [4:0]  r_prev, n_prev;
    logic        r_prev_v, n_prev_v;
    logic        r_pad, n_pad;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [5:0]  r_pa, r_pb;
    logic [4:0]  r_ks_a, r_ks_b;

    logic        place;
    logic [4:0]  place_l, place_idx;
    logic        rd_en, ks_rd_en;
    logic [4:0]  rd_a, rd_b;
    logic        x_ins;
    logic [4:0]  lmap;
    logic        can_push, out_push;
    t_out_item   out_data;
    logic [2:0]  r1, c1, r2, c2;
    logic [4:0]  ka, kb;

    function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
        cell_addr = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        wrap_inc = (v == LAST_COL) ? 3'd0 : v + 3'd1;
    endfunction

    assign can_push    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign x_ins     = r_prev_v && (i_cmd.sym == r_prev) && !i_cmd.space;
    assign lmap      = (i_cmd.sym == LET_J) ? LET_I : i_cmd.sym;
    assign place_idx = (place_l == LET_J) ? LET_I : place_l;

    // Row, column and rectangle rules on the registered lookups
    assign r1 = r_pa[5:3];
    assign c1 = r_pa[2:0];
    assign r2 = r_pb[5:3];
    assign c2 = r_pb[2:0];

    always_comb begin
        if (r1 == r2) begin
            ka = cell_addr(r1, wrap_inc(c1));
            kb = cell_addr(r1, wrap_inc(c2));
        end else if (c1 == c2) begin
            ka = cell_addr(wrap_inc(r1), c1);
            kb = cell_addr(wrap_inc(r2), c1);
        end else begin
            ka = cell_addr(r1, c2);
            kb = cell_addr(r2, c1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_row       = r_row;
        n_col       = r_col;
        n_used      = r_used;
        n_cand      = r_cand;
        n_key_ready = r_key_ready;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_prev      = r_prev;
        n_prev_v    = r_prev_v;
        n_pad       = r_pad;
        o_pop       = 1'b0;
        place       = 1'b0;
        place_l     = i_cmd.sym;
        rd_en       = 1'b0;
        rd_a        = i_cmd.sym;
        rd_b        = i_cmd.sym;
        ks_rd_en    = 1'b0;
        out_push    = 1'b0;
        out_data    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_KEY: begin
                            if (!r_key_ready && r_fill < 5'(NUM_CELLS)
                                && !r_used[i_cmd.sym]) begin
                                place   = 1'b1;
                                place_l = i_cmd.sym;
                            end
                        end
                        OP_DONE: begin
                            if (!r_key_ready) begin
                                n_cand  = '0;
                                n_state = S_FILL;
                            end
                        end
                        OP_TEXT: begin
                            if (r_key_ready) begin
                                n_prev   = i_cmd.sym;
                                n_prev_v = 1'b1;
                                if (x_ins) begin
                                    rd_en = 1'b1;
                                    if (r_pend_v) begin
                                        rd_a     = r_pend;
                                        rd_b     = LET_X;
                                        n_pend   = lmap;
                                        n_pend_v = 1'b1;
                                    end else begin
                                        rd_a     = LET_X;
                                        rd_b     = lmap;
                                        n_pend_v = 1'b0;
                                    end
                                end else if (!i_cmd.space) begin
                                    if (r_pend_v) begin
                                        rd_en    = 1'b1;
                                        rd_a     = r_pend;
                                        rd_b     = lmap;
                                        n_pend_v = 1'b0;
                                    end else begin
                                        n_pend   = lmap;
                                        n_pend_v = 1'b1;
                                    end
                                end
                                if (rd_en) begin
                                    n_pad   = 1'b0;
                                    n_state = S_POS;
                                end
                            end
                        end
                        default: begin
                            n_prev_v = 1'b0;
                            if (r_pend_v) begin
                                rd_en    = 1'b1;
                                rd_a     = r_pend;
                                rd_b     = LET_Z;
                                n_pend_v = 1'b0;
                                n_pad    = 1'b1;
                                n_state  = S_POS;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_fill >= 5'(NUM_CELLS) || r_cand >= 5'(NUM_LETTERS)) begin
                    n_key_ready = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    if (r_cand != LET_J && !r_used[r_cand]) begin
                        place   = 1'b1;
                        place_l = r_cand;
                    end
                    n_cand = r_cand + 5'd1;
                end
            end
            S_POS: begin
                ks_rd_en = 1'b1;
                n_state  = S_OUT1;
            end
            S_OUT1: begin
                if (can_push) begin
                    out_push = 1'b1;
                    out_data = '{cipher_letter: r_ks_a, last_of_run: 1'b0, padded_pair: r_pad};
                    n_state  = S_OUT2;
                end
            end
            S_OUT2: begin
                if (can_push) begin
                    out_push = 1'b1;
                    out_data = '{cipher_letter: r_ks_b, last_of_run: 1'b1, padded_pair: r_pad};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the fill cursor and mark the letter (I and J together)
        if (place) begin
            n_fill = r_fill + 5'd1;
            if (r_col == LAST_COL) begin
                n_col = 3'd0;
                n_row = r_row + 3'd1;
            end else begin
                n_col = r_col + 3'd1;
            end
            if (place_l == LET_I || place_l == LET_J) begin
                n_used[LET_I] = 1'b1;
                n_used[LET_J] = 1'b1;
            end else begin
                n_used[place_l] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_used      <= '0;
            r_cand      <= '0;
            r_key_ready <= 1'b0;
            r_pend      <= '0;
            r_pend_v    <= 1'b0;
            r_prev      <= '0;
            r_prev_v    <= 1'b0;
            r_pad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_row       <= n_row;
            r_col       <= n_col;
            r_used      <= n_used;
            r_cand      <= n_cand;
            r_key_ready <= n_key_ready;
            r_pend      <= n_pend;
            r_pend_v    <= n_pend_v;
            r_prev      <= n_prev;
            r_prev_v    <= n_prev_v;
            r_pad       <= n_pad;
            if (out_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place) begin
            r_key_sq[r_fill]  <= place_l;
            r_pos[place_idx]  <= {r_row, r_col};
        end
        if (rd_en) begin
            r_pa <= r_pos[rd_a];
            r_pb <= r_pos[rd_b];
        end
        if (ks_rd_en) begin
            r_ks_a <= r_key_sq[ka];
            r_ks_b <= r_key_sq[kb];
        end
    end

endmodule

### src/playfair_digraph_cipher.sv
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-------------------------------------
// in      | input     | i_in_valid / o_in_ready    | i_in_data  {opcode, symbol}
// out     | output    | o_out_valid / i_out_ready  | o_out_data {cipher_letter, last_of_run,
//         |           |                            |             padded_pair}
//
// The front takes one beat per cycle while the command queue has room.
// The back runs one command at a time: a key letter is placed when popped, key
// complete runs the pop, the fill sequencer at one alphabet candidate per cycle
// and a closing step, and a beat that closes a pair runs letter lookup, key square
// read and two output beats, each output beat held while i_out_ready is low.
// Reset (i_rst_n, synchronous, active low) empties the queue, drops the key and
// clears pending and previous letters; a fresh key must be loaded after it.
module playfair_digraph_cipher #(
    parameter int unsigned QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfc_pkg::t_out_item o_out_data
);
    import pfc_pkg::*;

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    // Front: classify each beat and drop the ones that can never matter
    pfc_front u_front (
        .i_in_data    (i_in_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Queue: decouple the front from the slow back commands
    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // Back: build the key square, pair letters, encipher and emit
    pfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### src/pfc_checker.sv
module pfc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pfc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pfc_pkg::t_out_item o_out_data
);
    import pfc_pkg::*;

    // Every emitted letter is a letter code, A to Z
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cipher_letter <= LAST_LET))
        else $error("cipher letter out of range");

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Reset drops any output beat
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the queue, so the input side is ready at once
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

### tb/tb_playfair_digraph_cipher.sv
`timescale 1ns / 100ps

import pfc_pkg::*;

// Tracks the key square and the digraph stream, and holds the cipher letters still owed.
class digraph_scoreboard;
    localparam int SIDE = 5;

    logic [4:0]  square [NUM_CELLS];
    logic [2:0]  row_of [NUM_LETTERS];
    logic [2:0]  col_of [NUM_LETTERS];
    logic [25:0] taken;
    int          fill_pos;
    bit          key_built;
    logic [4:0]  held_letter;
    bit          held_valid;
    logic [4:0]  last_sym;
    bit          last_sym_valid;
    t_out_item   cipher_q [$];
    int          errors;

    function new();
        taken          = '0;
        fill_pos       = 0;
        key_built      = 1'b0;
        held_letter    = '0;
        held_valid     = 1'b0;
        last_sym       = '0;
        last_sym_valid = 1'b0;
        errors         = 0;
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
        errors++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    // I and J share one cell, so claim both
    function void mark_taken(logic [4:0] l);
        if (l == LET_I || l == LET_J) begin
            taken[LET_I] = 1'b1;
            taken[LET_J] = 1'b1;
        end else begin
            taken[l] = 1'b1;
        end
    endfunction

    function void encipher_pair(logic [4:0] a, logic [4:0] b, bit pad,
                                ref t_out_item run [$]);
        int r1, c1, r2, c2;
        t_out_item o1, o2;
        r1 = row_of[a];
        c1 = col_of[a];
        r2 = row_of[b];
        c2 = col_of[b];
        o1 = '0;
        o2 = '0;
        if (r1 == r2) begin
            o1.cipher_letter = square[r1 * SIDE + (c1 + 1) % SIDE];
            o2.cipher_letter = square[r1 * SIDE + (c2 + 1) % SIDE];
        end else if (c1 == c2) begin
            o1.cipher_letter = square[((r1 + 1) % SIDE) * SIDE + c1];
            o2.cipher_letter = square[((r2 + 1) % SIDE) * SIDE + c1];
        end else begin
            o1.cipher_letter = square[r1 * SIDE + c2];
            o2.cipher_letter = square[r2 * SIDE + c1];
        end
        o1.padded_pair = pad;
        o2.padded_pair = pad;
        run.push_back(o1);
        run.push_back(o2);
    endfunction

    function void push_letter(logic [4:0] l, ref t_out_item run [$]);
        if (!held_valid) begin
            held_letter = l;
            held_valid  = 1'b1;
        end else begin
            held_valid = 1'b0;
            encipher_pair(held_letter, l, 1'b0, run);
        end
    endfunction

    // Advance the cipher state by one accepted input beat and queue its letters.
    function void note_beat(t_in_item beat);
        t_out_item  run [$];
        logic [4:0] sym;
        logic [4:0] l;
        sym = beat.symbol;
        case (beat.opcode)
            OP_KEY: begin
                if (!key_built && sym <= LAST_LET && fill_pos < NUM_CELLS && !taken[sym]) begin
                    square[fill_pos] = sym;
                    fill_pos++;
                    mark_taken(sym);
                end
            end
            OP_DONE: begin
                if (!key_built) begin
                    for (int cand = 0; cand < NUM_LETTERS && fill_pos < NUM_CELLS; cand++) begin
                        if (cand != LET_J && !taken[cand]) begin
                            square[fill_pos] = 5'(cand);
                            fill_pos++;
                            mark_taken(5'(cand));
                        end
                    end
                    for (int p = 0; p < NUM_CELLS; p++) begin
                        l = square[p];
                        if (l == LET_I || l == LET_J) begin
                            row_of[LET_I] = 3'(p / SIDE);
                            col_of[LET_I] = 3'(p % SIDE);
                            row_of[LET_J] = 3'(p / SIDE);
                            col_of[LET_J] = 3'(p % SIDE);
                        end else begin
                            row_of[l] = 3'(p / SIDE);
                            col_of[l] = 3'(p % SIDE);
                        end
                    end
                    key_built = 1'b1;
                end
            end
            OP_TEXT: begin
                if (key_built && sym <= SPACE_CODE) begin
                    // raw compare: a repeat inserts X regardless of pairing
                    if (last_sym_valid && sym == last_sym && sym != SPACE_CODE)
                        push_letter(LET_X, run);
                    if (sym != SPACE_CODE)
                        push_letter((sym == LET_J) ? LET_I : sym, run);
                    last_sym       = sym;
                    last_sym_valid = 1'b1;
                end
            end
            default: begin
                if (held_valid) begin
                    held_valid = 1'b0;
                    encipher_pair(held_letter, LET_Z, 1'b1, run);
                end
                last_sym_valid = 1'b0;
            end
        endcase
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            cipher_q.push_back(run[i]);
    endfunction

    task check_beat(t_out_item got);
        t_out_item want;
        if (cipher_q.size() == 0) begin
            report_mismatch("unexpected cipher beat, letter", got.cipher_letter, -1);
            return;
        end
        want = cipher_q.pop_front();
        if (got.cipher_letter !== want.cipher_letter)
            report_mismatch("cipher_letter", got.cipher_letter, want.cipher_letter);
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (got.padded_pair !== want.padded_pair)
            report_mismatch("padded_pair", got.padded_pair, want.padded_pair);
    endtask
endclass

module tb_playfair_digraph_cipher;

    localparam int ITEMS_PER_PHASE = 93;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    digraph_scoreboard sb;

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_req       = 1'b0;
    bit         holding        = 1'b0;
    int         cycles         = 0;
    logic [4:0] last_text      = '0;

    playfair_digraph_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_playfair_digraph_cipher: done, errors");
            $finish;
        end
    end

    // Receiver: hold off for a long stretch when asked, else stall at random
    always @(posedge i_clk) begin
        if (holding) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count out the long hold-off once it is requested
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat(o_out_data);
    end

    // Offer one beat, idling first at random; return at the edge that takes it.
    task automatic send_beat(input logic [1:0] op, input logic [4:0] sym);
        t_in_item beat;
        beat.opcode = op;
        beat.symbol = sym;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(beat);
    endtask

    // Mostly plaintext with frequent repeats and I/J; some ends of message and noise.
    task automatic send_random();
        int         pick;
        logic [1:0] op;
        logic [4:0] sym;
        pick = $urandom_range(99);
        op   = OP_TEXT;
        if (pick < 15) begin
            sym = last_text;
        end else if (pick < 25) begin
            sym = $urandom_range(1) ? LET_I : LET_J;
        end else if (pick < 60) begin
            sym = 5'($urandom_range(25));
        end else if (pick < 68) begin
            sym = SPACE_CODE;
        end else if (pick < 80) begin
            op  = OP_END;
            sym = 5'($urandom_range(31));
        end else if (pick < 86) begin
            sym = 5'($urandom_range(31, 27));
        end else if (pick < 92) begin
            op  = OP_KEY;
            sym = 5'($urandom_range(31));
        end else begin
            op  = OP_DONE;
            sym = 5'($urandom_range(31));
        end
        if (op == OP_TEXT && sym <= SPACE_CODE)
            last_text = sym;
        send_beat(op, sym);
    endtask

    initial begin
        int idle_tab  [4];
        int stall_tab [4];

        idle_tab  = '{0, 59, 0, 21};
        stall_tab = '{0, 0, 59, 21};
        sb = new();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before the key is complete: plaintext and end of message do nothing
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_END, 5'd0);
        // Keyword with J, a space, an out-of-range code, I after J, and a repeat
        send_beat(OP_KEY, LET_J);
        send_beat(OP_KEY, SPACE_CODE);
        send_beat(OP_KEY, 5'd31);
        send_beat(OP_KEY, LET_I);
        repeat (3) send_beat(OP_KEY, 5'($urandom_range(25)));
        send_beat(OP_KEY, LET_Z);
        send_beat(OP_KEY, 5'd0);
        send_beat(OP_KEY, 5'd0);
        send_beat(OP_DONE, 5'd0);
        // Repeated key complete and a late key letter are dropped
        send_beat(OP_DONE, 5'd31);
        send_beat(OP_KEY, 5'd1);
        // Double letter gets an X; I after J, spaces, out-of-range text
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_TEXT, LET_J);
        send_beat(OP_TEXT, LET_I);
        send_beat(OP_TEXT, SPACE_CODE);
        send_beat(OP_TEXT, SPACE_CODE);
        send_beat(OP_TEXT, LET_I);
        send_beat(OP_TEXT, 5'd31);
        send_beat(OP_TEXT, LET_Z);
        // Odd letter gets a Z pad; then an empty message
        send_beat(OP_END, 5'd0);
        send_beat(OP_END, 5'd31);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            // Starve the output so the block fills up and stalls its input
            if (ph == 0)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random();
        end

        i_in_valid <= 1'b0;
        while (sb.cipher_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb_playfair_digraph_cipher: done, clean");
        else
            $display("tb_playfair_digraph_cipher: done, errors");
        $finish;
    end

endmodule

### sim.f
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_queue.sv
src/pfc_back.sv
src/playfair_digraph_cipher.sv
src/pfc_checker.sv
tb/tb_playfair_digraph_cipher.sv
